>>> sv/hdbp_pkg.sv
// Shared types and constants for the hex data body parser.
`default_nettype none
package hdbp_pkg;

  // Parse phases, one-hot
  typedef enum logic [8:0] {
    PH_WAIT    = 9'b000000001,
    PH_ITEMS   = 9'b000000010,
    PH_SLASH   = 9'b000000100,
    PH_COMMENT = 9'b000001000,
    PH_STARS   = 9'b000010000,
    PH_DOLLAR  = 9'b000100000,
    PH_DIGIT1  = 9'b001000000,
    PH_DIGIT2  = 9'b010000000,
    PH_TAIL    = 9'b100000000
  } phase_t;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NO_BRACE   = 3'd0;
  localparam logic [2:0] ERR_END        = 3'd1;
  localparam logic [2:0] ERR_BAD_CHAR   = 3'd2;
  localparam logic [2:0] ERR_NO_STAR    = 3'd3;
  localparam logic [2:0] ERR_NO_QUOTE   = 3'd4;
  localparam logic [2:0] ERR_BAD_HEX    = 3'd5;
  localparam logic [2:0] ERR_BAD_TAIL   = 3'd6;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Character classes of one text byte
  typedef struct packed {
    logic       is_nul;
    logic       is_white;
    logic       is_space;
    logic       is_quote;
    logic       is_dollar;
    logic       is_star;
    logic       is_slash;
    logic       is_semi;
    logic       is_lbrace;
    logic       is_rbrace;
    logic       hex_ok;
    logic [3:0] hex_val;
  } char_class_t;

  // One result of a parse step
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [2:0] error_code;
  } step_result_t;

endpackage
`default_nettype wire

>>> sv/hdbp_classify.sv
// Character classifier and hex digit decoder for one text byte.
`default_nettype none
module hdbp_classify (
  input  wire logic [7:0]               ch,
  output hdbp_pkg::char_class_t         cls
);

  always_comb begin
    cls.is_nul    = (ch == hdbp_pkg::CH_NUL);
    cls.is_space  = (ch == hdbp_pkg::CH_SPACE);
    cls.is_white  = (ch == hdbp_pkg::CH_SPACE) || (ch == hdbp_pkg::CH_TAB) ||
                    (ch == hdbp_pkg::CH_LF) || (ch == hdbp_pkg::CH_CR);
    cls.is_quote  = (ch == hdbp_pkg::CH_QUOTE);
    cls.is_dollar = (ch == hdbp_pkg::CH_DOLLAR);
    cls.is_star   = (ch == hdbp_pkg::CH_STAR);
    cls.is_slash  = (ch == hdbp_pkg::CH_SLASH);
    cls.is_semi   = (ch == hdbp_pkg::CH_SEMI);
    cls.is_lbrace = (ch == hdbp_pkg::CH_LBRACE);
    cls.is_rbrace = (ch == hdbp_pkg::CH_RBRACE);
    cls.hex_ok    = 1'b0;
    cls.hex_val   = 4'd0;
    // decimal digits, then upper and lower case letters A to F
    if (ch >= 8'h30 && ch <= 8'h39) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = ch[3:0];
    end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = ch[3:0] + 4'd9;
    end
  end

endmodule
`default_nettype wire

>>> sv/hdbp_step.sv
// Next-state and result logic of the body parser for one classified byte.
`default_nettype none
module hdbp_step (
  input  wire hdbp_pkg::phase_t        phase,
  input  wire logic [3:0]              high_nibble,
  input  wire hdbp_pkg::char_class_t   cls,
  output hdbp_pkg::phase_t             phase_next,
  output logic [3:0]                   high_nibble_next,
  output hdbp_pkg::step_result_t       res
);

  logic       fail;
  logic [2:0] fail_code;

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    fail             = 1'b0;
    fail_code        = hdbp_pkg::ERR_NO_BRACE;
    res              = '0;
    unique case (phase)
      hdbp_pkg::PH_ITEMS: begin
        if (cls.is_white) begin
        end else if (cls.is_slash) begin
          phase_next = hdbp_pkg::PH_SLASH;
        end else if (cls.is_dollar) begin
          phase_next = hdbp_pkg::PH_DOLLAR;
        end else if (cls.is_rbrace) begin
          phase_next = hdbp_pkg::PH_TAIL;
        end else begin
          fail      = 1'b1;
          fail_code = cls.is_nul ? hdbp_pkg::ERR_END : hdbp_pkg::ERR_BAD_CHAR;
        end
      end
      hdbp_pkg::PH_SLASH: begin
        if (cls.is_star) begin
          phase_next = hdbp_pkg::PH_COMMENT;
        end else begin
          fail      = 1'b1;
          fail_code = hdbp_pkg::ERR_NO_STAR;
        end
      end
      hdbp_pkg::PH_COMMENT: begin
        if (cls.is_nul) begin
          fail      = 1'b1;
          fail_code = hdbp_pkg::ERR_END;
        end else if (cls.is_star) begin
          phase_next = hdbp_pkg::PH_STARS;
        end
      end
      hdbp_pkg::PH_STARS: begin
        if (cls.is_nul) begin
          fail      = 1'b1;
          fail_code = hdbp_pkg::ERR_END;
        end else if (cls.is_slash) begin
          phase_next = hdbp_pkg::PH_ITEMS;
        end else if (!cls.is_star) begin
          phase_next = hdbp_pkg::PH_COMMENT;
        end
      end
      hdbp_pkg::PH_DOLLAR: begin
        if (cls.is_quote) begin
          phase_next = hdbp_pkg::PH_DIGIT1;
        end else begin
          fail      = 1'b1;
          fail_code = hdbp_pkg::ERR_NO_QUOTE;
        end
      end
      hdbp_pkg::PH_DIGIT1: begin
        if (cls.is_space) begin
        end else if (cls.is_quote) begin
          phase_next = hdbp_pkg::PH_ITEMS;
        end else if (cls.hex_ok) begin
          high_nibble_next = cls.hex_val;
          phase_next       = hdbp_pkg::PH_DIGIT2;
        end else begin
          fail      = 1'b1;
          fail_code = hdbp_pkg::ERR_BAD_HEX;
        end
      end
      hdbp_pkg::PH_DIGIT2: begin
        if (cls.hex_ok) begin
          phase_next    = hdbp_pkg::PH_DIGIT1;
          res.valid     = 1'b1;
          res.kind      = hdbp_pkg::KIND_DATA;
          res.data_byte = {high_nibble, cls.hex_val};
        end else begin
          fail      = 1'b1;
          fail_code = hdbp_pkg::ERR_BAD_HEX;
        end
      end
      hdbp_pkg::PH_TAIL: begin
        if (cls.is_white) begin
        end else if (cls.is_semi) begin
          phase_next       = hdbp_pkg::PH_WAIT;
          high_nibble_next = 4'd0;
          res.valid        = 1'b1;
          res.kind         = hdbp_pkg::KIND_DONE;
        end else begin
          fail      = 1'b1;
          fail_code = hdbp_pkg::ERR_BAD_TAIL;
        end
      end
      default: begin
        // waiting for an opening brace
        phase_next = hdbp_pkg::PH_WAIT;
        if (cls.is_white) begin
        end else if (cls.is_lbrace) begin
          phase_next = hdbp_pkg::PH_ITEMS;
        end else begin
          fail      = 1'b1;
          fail_code = hdbp_pkg::ERR_NO_BRACE;
        end
      end
    endcase
    if (fail) begin
      phase_next       = hdbp_pkg::PH_WAIT;
      high_nibble_next = 4'd0;
      res.valid        = 1'b1;
      res.kind         = hdbp_pkg::KIND_ERROR;
      res.data_byte    = 8'd0;
      res.error_code   = fail_code;
    end
  end

endmodule
`default_nettype wire

>>> sv/hex_data_body_parser.sv
// Top level of the hex data body parser: input register, parse step, result register.
`default_nettype none
// Parses the body of a resource data statement one text byte per request:
// whitespace, an opening brace, any mix of slash-star comments and
// dollar-quoted hex strings, a closing brace and a semicolon. Each pair of
// hex digits gives a data result (kind 0), the semicolon gives a completion
// result (kind 1), and any malformed input gives an error result (kind 2)
// with a code, after which the parser waits for a new opening brace. A zero
// byte where a token is expected stands for end of input. A byte is taken
// into an input register, passes one short classify-and-step stage and lands
// in the result register, so the block sustains one byte per cycle while the
// result side does not stall. The input register
// moves forward whenever the result register is empty or being drained, so a
// stall on the result side reaches the byte side in the same cycle.
module hex_data_body_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  // text byte channel
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  wire logic [7:0] in_byte,
  // result channel
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [1:0]      kind,
  output logic [7:0]      data_byte,
  output logic [2:0]      error_code
);

  // input register
  logic       hold_valid;
  logic [7:0] hold_byte;

  // parser state
  hdbp_pkg::phase_t phase;
  hdbp_pkg::phase_t phase_next;
  logic [3:0]       high_nibble;
  logic [3:0]       high_nibble_next;

  hdbp_pkg::char_class_t  cls;
  hdbp_pkg::step_result_t res;

  logic out_free;
  logic advance;

  // result register is free when empty or being taken this cycle
  assign out_free   = !result_valid || !result_stall;
  assign advance    = hold_valid && out_free;
  // hold the request while the held byte cannot move on
  assign byte_stall = hold_valid && !out_free;

  hdbp_classify u_classify (
    .ch  (hold_byte),
    .cls (cls)
  );

  hdbp_step u_step (
    .phase            (phase),
    .high_nibble      (high_nibble),
    .cls              (cls),
    .phase_next       (phase_next),
    .high_nibble_next (high_nibble_next),
    .res              (res)
  );

  // input register: load on accept, drop after advance
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      hold_byte <= in_byte;
    end
  end

  // parser state advances with each byte that leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= hdbp_pkg::PH_WAIT;
      high_nibble <= 4'd0;
    end else if (advance) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
    end
  end

  // result register: a byte that yields no result leaves it empty
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= advance && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid && out_free) begin
      kind       <= res.kind;
      data_byte  <= res.data_byte;
      error_code <= res.error_code;
    end
  end

`ifndef SYNTHESIS
  a_phase_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(phase))
    else $error("parse phase is not one-hot");

  a_error_returns_wait: assert property (@(posedge clk) disable iff (rst)
    advance && res.valid && (res.kind == hdbp_pkg::KIND_ERROR) |=> phase == hdbp_pkg::PH_WAIT)
    else $error("error did not return parser to waiting for brace");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (kind == hdbp_pkg::KIND_DATA) || (kind == hdbp_pkg::KIND_DONE) ||
                     (kind == hdbp_pkg::KIND_ERROR))
    else $error("result kind out of range");

  a_code_zero_unless_error: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind != hdbp_pkg::KIND_ERROR) |-> error_code == hdbp_pkg::ERR_NO_BRACE)
    else $error("error code set on a non-error result");

  a_stall_when_blocked: assert property (@(posedge clk) disable iff (rst)
    hold_valid && result_valid && result_stall |=> hold_valid)
    else $error("held byte lost while result side stalled");
`endif

endmodule
`default_nettype wire

>>> dv/body_result_check.sv
// Result checker for the hex data body parser: predicts each result and compares it.
module body_result_check
  import hdbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic       byte_stall,
  input  logic [7:0] in_byte,
  input  logic       result_valid,
  input  logic       result_stall,
  input  logic [1:0] kind,
  input  logic [7:0] data_byte,
  input  logic [2:0] error_code,
  output int         fail_total,
  output int         results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] NO_CODE = 3'd0;
  localparam logic [4:0] HEX_BAD = 5'd16;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] code;
  } body_result_t;

  body_result_t expected_results[$];
  phase_t       text_phase;
  logic [3:0]   high_digit;

  function automatic logic is_white(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  // Value of a hex digit in either case, or HEX_BAD.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
    return HEX_BAD;
  endfunction

  task automatic queue_result(input logic [1:0] k, input logic [7:0] d, input logic [2:0] e);
    expected_results.push_back('{kind: k, data: d, code: e});
  endtask

  task automatic parse_error(input logic [2:0] e);
    text_phase = PH_WAIT;
    high_digit = 4'd0;
    queue_result(KIND_ERROR, 8'h00, e);
  endtask

  // Advance the parser by one text byte.
  task automatic step_parser(input logic [7:0] c);
    logic [4:0] hv;
    hv = hex_value(c);
    case (text_phase)
      PH_ITEMS: begin
        if (!is_white(c)) begin
          if (c == CH_SLASH) text_phase = PH_SLASH;
          else if (c == CH_DOLLAR) text_phase = PH_DOLLAR;
          else if (c == CH_RBRACE) text_phase = PH_TAIL;
          else if (c == CH_NUL) parse_error(ERR_END);
          else parse_error(ERR_BAD_CHAR);
        end
      end
      PH_SLASH: begin
        if (c == CH_STAR) text_phase = PH_COMMENT;
        else parse_error(ERR_NO_STAR);
      end
      PH_COMMENT: begin
        if (c == CH_NUL) parse_error(ERR_END);
        else if (c == CH_STAR) text_phase = PH_STARS;
      end
      PH_STARS: begin
        if (c == CH_NUL) parse_error(ERR_END);
        else if (c == CH_SLASH) text_phase = PH_ITEMS;
        else if (c != CH_STAR) text_phase = PH_COMMENT;
      end
      PH_DOLLAR: begin
        if (c == CH_QUOTE) text_phase = PH_DIGIT1;
        else parse_error(ERR_NO_QUOTE);
      end
      PH_DIGIT1: begin
        if (c == CH_QUOTE) text_phase = PH_ITEMS;
        else if (c != CH_SPACE) begin
          if (hv == HEX_BAD) parse_error(ERR_BAD_HEX);
          else begin
            high_digit = hv[3:0];
            text_phase = PH_DIGIT2;
          end
        end
      end
      PH_DIGIT2: begin
        if (hv == HEX_BAD) parse_error(ERR_BAD_HEX);
        else begin
          text_phase = PH_DIGIT1;
          queue_result(KIND_DATA, {high_digit, hv[3:0]}, NO_CODE);
        end
      end
      PH_TAIL: begin
        if (c == CH_SEMI) begin
          text_phase = PH_WAIT;
          high_digit = 4'd0;
          queue_result(KIND_DONE, 8'h00, NO_CODE);
        end else if (!is_white(c)) begin
          parse_error(ERR_BAD_TAIL);
        end
      end
      default: begin
        text_phase = PH_WAIT;
        if (c == CH_LBRACE) text_phase = PH_ITEMS;
        else if (!is_white(c)) parse_error(ERR_NO_BRACE);
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    fail_total++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    body_result_t want;
    if (rst) begin
      text_phase = PH_WAIT;
      high_digit = 4'd0;
      expected_results.delete();
      fail_total = 0;
    end else begin
      // drain before predict: a result never belongs to a byte of the same edge
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d data %h code %0d",
                                    kind, data_byte, error_code));
        end else begin
          want = expected_results.pop_front();
          if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
          if (data_byte !== want.data)
            report_mismatch($sformatf("data_byte %h, expected %h", data_byte, want.data));
          if (error_code !== want.code)
            report_mismatch($sformatf("error_code %0d, expected %0d", error_code, want.code));
        end
      end
      if (byte_valid && !byte_stall) step_parser(in_byte);
    end
    results_due = expected_results.size();
  end

endmodule

>>> dv/hex_data_body_parser_tb.sv
// Top of the hex data body parser testbench: clock, reset, text stimulus and verdict.
module hex_data_body_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hdbp_pkg::*;

  localparam int           ITEM_TARGET  = 1100;
  localparam int           CYCLE_LIMIT  = 400000;
  localparam int           HOLD_AT      = 400;   // requests sent before the long hold-off
  localparam int           HOLD_CYCLES  = 300;
  localparam int           DRAIN_CYCLES = 16;    // watch for stray results after the drain
  localparam logic [127:0] LOWER_DIGITS = "0123456789abcdef";
  localparam logic [127:0] UPPER_DIGITS = "0123456789ABCDEF";

  logic       clk = 1'b0;
  logic       rst;
  logic       byte_valid;
  logic       byte_stall;
  logic [7:0] in_byte;
  logic       result_valid;
  logic       result_stall;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [2:0] error_code;

  // The result stall is the OR of the random pattern and the long hold-off,
  // each owned by its own process and both driven at the falling edge.
  logic rnd_stall = 1'b0;
  logic hold_off  = 1'b0;
  assign result_stall = rnd_stall | hold_off;

  int         sent_count  = 0;
  int         cycle_count = 0;
  int         fail_total;
  int         results_due;
  logic [7:0] text_q[$];
  bit         steady;        // send the current text with no gaps
  int         stretch;
  bit         calm;

  hex_data_body_parser dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .in_byte      (in_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .data_byte    (data_byte),
    .error_code   (error_code)
  );

  body_result_check check (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .in_byte      (in_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .data_byte    (data_byte),
    .error_code   (error_code),
    .fail_total   (fail_total),
    .results_due  (results_due)
  );

  always #2 clk = ~clk;

  // Watchdog: end the run if it hangs anywhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Half the time no gap, usually a short one, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 1) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Offer one text byte at the falling edge and hold it until accepted.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_byte    <= b;
    byte_valid <= 1'b1;
    do @(posedge clk); while (byte_stall);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i]);
    text_q.delete();
  endtask

  function automatic logic [7:0] white_char();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  task automatic add_white(input int most);
    repeat ($urandom_range(0, most)) text_q.push_back(white_char());
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [127:0] digits;
    digits = $urandom_range(0, 1) ? UPPER_DIGITS : LOWER_DIGITS;
    return digits[8 * (15 - nib) +: 8];
  endfunction

  // Comment body avoids slashes so only the star run at the end closes it;
  // stars inside still walk the star-run states.
  task automatic add_comment();
    logic [7:0] b;
    text_q.push_back(CH_SLASH);
    text_q.push_back(CH_STAR);
    repeat ($urandom_range(0, 5)) begin
      b = 8'($urandom_range(1, 255));
      if (b == CH_SLASH) b = CH_STAR;
      text_q.push_back(b);
    end
    repeat ($urandom_range(1, 3)) text_q.push_back(CH_STAR);
    text_q.push_back(CH_SLASH);
  endtask

  task automatic add_hex_string();
    logic [7:0] v;
    text_q.push_back(CH_DOLLAR);
    text_q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 2) == 0) text_q.push_back(CH_SPACE);
      v = 8'($urandom_range(0, 255));
      text_q.push_back(hex_char(v[7:4]));
      text_q.push_back(hex_char(v[3:0]));
    end
    text_q.push_back(CH_QUOTE);
  endtask

  // Well-formed body with random content; about a third get one byte
  // overwritten so every error path is hit from deep states.
  task automatic build_body();
    int idx;
    add_white(2);
    text_q.push_back(CH_LBRACE);
    repeat ($urandom_range(0, 3)) begin
      add_white(2);
      if ($urandom_range(0, 1)) add_comment();
      else add_hex_string();
    end
    add_white(2);
    text_q.push_back(CH_RBRACE);
    add_white(2);
    text_q.push_back(CH_SEMI);
    if ($urandom_range(0, 99) < 35) begin
      idx = $urandom_range(0, text_q.size() - 1);
      text_q[idx] = ($urandom_range(0, 3) == 0) ? CH_NUL : 8'($urandom_range(0, 255));
    end
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Random receiver stalls: stretches with no stalls at all, and stretches
  // with short stalls and the odd long one.
  initial begin
    forever begin
      stretch = $urandom_range(20, 100);
      calm    = ($urandom_range(0, 9) < 3);
      repeat (stretch) begin
        @(negedge clk);
        if (calm) begin
          rnd_stall <= 1'b0;
        end else if ($urandom_range(0, 29) == 0) begin
          rnd_stall <= 1'b1;
          repeat ($urandom_range(10, 40)) @(negedge clk);
        end else begin
          rnd_stall <= ($urandom_range(0, 3) == 0);
        end
      end
    end
  end

  // Hold off the result side for a long stretch while bytes keep coming,
  // so the pipeline fills and backs up into the byte channel.
  initial begin
    wait (sent_count >= HOLD_AT);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    rst        = 1'b1;
    byte_valid = 1'b0;
    in_byte    = 8'h00;
    steady     = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed opening: zero and all-ones before a brace, zero between items,
    // a star run closing a comment, a space before a pair, mixed-case digits,
    // whitespace before the semicolon, and a quote where a second digit belongs.
    text_q = '{CH_NUL, CH_SPACE, 8'hFF, CH_LBRACE, CH_NUL,
               CH_LBRACE, CH_SLASH, CH_STAR, CH_STAR, CH_STAR, CH_SLASH,
               CH_DOLLAR, CH_QUOTE, CH_SPACE, "a", "F", CH_QUOTE,
               CH_RBRACE, CH_LF, CH_SEMI,
               CH_LBRACE, CH_DOLLAR, CH_QUOTE, "9", CH_QUOTE};
    send_text();

    // Random part: mostly bodies, the rest raw noise.
    while (sent_count < ITEM_TARGET) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 8) build_body();
      else add_noise();
      send_text();
    end
    byte_valid <= 1'b0;

    // Drain every outstanding result, then watch for strays.
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_total == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
